FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL files; only the sequencer (tdsk_seq) includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/tdsk_pkg.sv
// Types, constants and key derivation functions for the seeded-key TEA decryptor.
`default_nettype none

package tdsk_pkg;

    localparam logic [31:0] TEA_SUM_START = 32'hC6EF3720;
    localparam logic [31:0] TEA_DELTA     = 32'h9E3779B9;
    localparam logic [15:0] SEED_RESET    = 16'd10000;
    localparam int unsigned HALF_STEPS    = 64;   // 32 TEA rounds of two half-rounds each
    localparam int unsigned STEP_W        = $clog2(HALF_STEPS);

    // register index, taken from paddr[2]
    localparam logic REG_KEY_SEED    = 1'b0;
    localparam logic REG_REPEAT_CODE = 1'b1;

    typedef logic [3:0][31:0] t_key;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    typedef struct packed {
        logic load;        // take a new item into the working registers
        logic step;        // apply one half-round
        logic half;        // 0: update second word, 1: update first word
        logic sum_reload;  // end of one decryption pass
        logic out_load;    // move result into the output register
    } t_ctrl;

    function automatic logic [15:0] lfsr_next(input logic [15:0] s);
        logic fb;
        fb = s[0] ^ s[2] ^ s[3] ^ s[5];
        return {fb, s[15:1]};
    endfunction

    // Eight LFSR states in pairs: high half first, low half second.
    function automatic t_key derive_key(input logic [15:0] seed);
        logic [15:0] s;
        logic [15:0] hi;
        t_key        k;
        s  = seed;
        hi = '0;
        k  = '0;
        for (int i = 0; i < 4; i++) begin
            s    = lfsr_next(s);
            hi   = s;
            s    = lfsr_next(s);
            k[i] = {hi, s};
        end
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tdsk_cfg.sv
// Configuration registers, APB-style access and key expansion from the seed.
`default_nettype none

module tdsk_cfg
    import tdsk_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_key             o_key,
    output logic      [2:0]  o_repeat_code
);

    logic [15:0] r_key_seed;
    logic [2:0]  r_repeat_code;
    t_key        r_key;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_seed    <= SEED_RESET;
            r_repeat_code <= '0;
            r_key         <= derive_key(SEED_RESET);
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_KEY_SEED: begin
                    r_key_seed <= pwdata[15:0];
                    r_key      <= derive_key(pwdata[15:0]);
                end
                REG_REPEAT_CODE: begin
                    r_repeat_code <= pwdata[2:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_KEY_SEED:    prdata = {16'd0, r_key_seed};
            REG_REPEAT_CODE: prdata = {29'd0, r_repeat_code};
            default:         prdata = '0;
        endcase
    end

    assign o_key         = r_key;
    assign o_repeat_code = r_repeat_code;

endmodule

`default_nettype wire

FILE: rtl/core/tdsk_round.sv
// Shared TEA half-round unit: target minus the mixed function of the other word.
`default_nettype none

module tdsk_round
    import tdsk_pkg::*;
(
    input  wire logic [31:0] i_word,
    input  wire logic [31:0] i_target,
    input  wire logic [31:0] i_sum,
    input  wire logic [31:0] i_key_a,
    input  wire logic [31:0] i_key_b,
    output logic      [31:0] o_result
);

    logic [31:0] mix;

    assign mix      = ((i_word << 4) + i_key_a) ^ (i_word + i_sum) ^ ((i_word >> 5) + i_key_b);
    assign o_result = i_target - mix;

endmodule

`default_nettype wire

FILE: rtl/core/tdsk_seq.sv
// Sequencer: half-round and pass counters, item handshake and result hand-off.
`default_nettype none
`include "assert_macros.svh"

module tdsk_seq
    import tdsk_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_out_free,
    input  wire logic [2:0] i_repeat_code,
    output t_ctrl           o_ctrl
);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [2:0]          r_pass, n_pass;
    logic                accept;
    logic                last_step;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid & ~o_in_stall;
    assign last_step  = (r_step == STEP_W'(HALF_STEPS - 1));

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_pass  = r_pass;
        o_ctrl  = '0;
        o_ctrl.half = r_step[0];
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_ctrl.load = 1'b1;
                    n_step      = '0;
                    n_pass      = '0;
                    n_state     = ST_RUN;
                end
            end
            ST_RUN: begin
                o_ctrl.step = 1'b1;
                n_step      = r_step + 1'b1;
                if (last_step) begin
                    o_ctrl.sum_reload = 1'b1;
                    if (r_pass == i_repeat_code) begin
                        n_state = ST_FIN;
                    end else begin
                        n_pass = r_pass + 1'b1;
                    end
                end
            end
            ST_FIN: begin
                if (i_out_free) begin
                    o_ctrl.out_load = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_pass  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_pass  <= n_pass;
        end
    end

    `ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, accept, (r_state == ST_RUN) && (r_step == '0) && (r_pass == '0), "item accepted but run did not start clean")
    `ASSERT_NEXT(a_last_pass_ends, i_clk, i_rst_n, (r_state == ST_RUN) && last_step && (r_pass == i_repeat_code), r_state == ST_FIN, "final half-round did not finish the item")
    `ASSERT_SAME(a_out_load_fin, i_clk, i_rst_n, o_ctrl.out_load, (r_state == ST_FIN) && i_out_free, "result moved while output busy or not finished")

endmodule

`default_nettype wire

FILE: rtl/core/tea_decrypt_seeded_key_unit.sv
// Seeded-key TEA decryptor: top level with working registers and output register.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one 64-bit ciphertext block as
//   i_cipher_first and i_cipher_second. Output channel (o_out_valid / i_out_stall)
//   returns the plaintext words. An item moves when valid is high and stall is low.
//   The APB-style port holds key_seed at 0x0 and repeat_code at 0x4; write them only
//   while the block is idle. The 128-bit key is expanded from the seed on the write.
//   One shared half-round unit runs twice per TEA cycle, and a block makes
//   repeat_code + 1 decryption passes in the unit; the result then moves into the
//   output register, which drives o_out_valid. One item is in work at a time;
//   o_in_stall is high while busy, so a new item is taken only after the last one
//   has moved into the output register.
//   A finished result waits in the output register, and the next item can be taken
//   meanwhile; if the receiver still stalls when that item completes, the block
//   holds it until the output register frees.
//   Reset (synchronous, active low) restores seed 10000, repeat code 0, and empties
//   the block.
`default_nettype none

module tea_decrypt_seeded_key_unit
    import tdsk_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_cipher_first,
    input  wire logic [31:0] i_cipher_second,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [31:0] o_plain_first,
    output logic      [31:0] o_plain_second
);

    t_key        key;
    logic [2:0]  repeat_code;
    t_ctrl       ctrl;
    logic        out_free;

    logic [31:0] r_y, r_z, r_sum;
    logic [31:0] r_plain_first, r_plain_second;
    logic        r_out_valid;

    logic [31:0] rnd_word, rnd_target, rnd_key_a, rnd_key_b, rnd_result;

    tdsk_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_key         (key),
        .o_repeat_code (repeat_code)
    );

    tdsk_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_out_free    (out_free),
        .i_repeat_code (repeat_code),
        .o_ctrl        (ctrl)
    );

    // first half updates z from y with keys 2/3, second updates y from z with keys 0/1
    always_comb begin
        if (ctrl.half) begin
            rnd_word   = r_z;
            rnd_target = r_y;
            rnd_key_a  = key[0];
            rnd_key_b  = key[1];
        end else begin
            rnd_word   = r_y;
            rnd_target = r_z;
            rnd_key_a  = key[2];
            rnd_key_b  = key[3];
        end
    end

    tdsk_round u_round (
        .i_word   (rnd_word),
        .i_target (rnd_target),
        .i_sum    (r_sum),
        .i_key_a  (rnd_key_a),
        .i_key_b  (rnd_key_b),
        .o_result (rnd_result)
    );

    always_ff @(posedge i_clk) begin
        if (ctrl.load) begin
            r_y <= i_cipher_first;
            r_z <= i_cipher_second;
        end else if (ctrl.step) begin
            if (ctrl.half) begin
                r_y <= rnd_result;
            end else begin
                r_z <= rnd_result;
            end
        end

        priority if (ctrl.load || ctrl.sum_reload) begin
            r_sum <= TEA_SUM_START;
        end else if (ctrl.step && ctrl.half) begin
            r_sum <= r_sum - TEA_DELTA;
        end else begin
            r_sum <= r_sum;
        end

        if (ctrl.out_load) begin
            r_plain_first  <= r_y;
            r_plain_second <= r_z;
        end
    end

    assign out_free = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_plain_first  = r_plain_first;
    assign o_plain_second = r_plain_second;

endmodule

`default_nettype wire

FILE: tb/sv/tea_decrypt_seeded_key_checker.sv
// Checker for the seeded-key TEA decryptor: follows the register writes, predicts and compares.
`timescale 1ns / 1ps

module tea_decrypt_seeded_key_checker
    import tdsk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        i_in_valid,
    input  logic        o_in_stall,
    input  logic [31:0] i_cipher_first,
    input  logic [31:0] i_cipher_second,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] o_plain_first,
    input  logic [31:0] o_plain_second,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] first;
        logic [31:0] second;
    } t_plain_pair;

    t_plain_pair plain_q[$];
    logic [15:0] seed_r;
    logic [2:0]  passes_code_r;
    int          mism_cnt;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mism_cnt     = 0;
    end

    // Eight successive LFSR states, paired high half then low half per key word
    function automatic t_key seed_to_key(input logic [15:0] seed);
        logic [15:0] st;
        logic [15:0] states [8];
        t_key        k;
        st = seed;
        for (int n = 0; n < 8; n++) begin
            st        = {st[0] ^ st[2] ^ st[3] ^ st[5], st[15:1]};
            states[n] = st;
        end
        for (int w = 0; w < 4; w++) begin
            k[w] = {states[2*w], states[2*w+1]};
        end
        return k;
    endfunction

    function automatic t_plain_pair tea_plain_of(input logic [31:0] c0, input logic [31:0] c1,
                                                 input logic [15:0] seed,
                                                 input logic [2:0] code);
        t_key        k;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] sum;
        t_plain_pair res;
        k = seed_to_key(seed);
        y = c0;
        z = c1;
        for (int pass = 0; pass <= int'(code); pass++) begin
            sum = TEA_SUM_START;
            for (int c = 0; c < 32; c++) begin
                z   = z - (((y << 4) + k[2]) ^ (y + sum) ^ ((y >> 5) + k[3]));
                y   = y - (((z << 4) + k[0]) ^ (z + sum) ^ ((z >> 5) + k[1]));
                sum = sum - TEA_DELTA;
            end
        end
        res.first  = y;
        res.second = z;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_plain_pair want;
        if (!i_rst_n) begin
            seed_r        = SEED_RESET;
            passes_code_r = '0;
            plain_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_KEY_SEED) begin
                    seed_r = pwdata[15:0];
                end else begin
                    passes_code_r = pwdata[2:0];
                end
            end
            // retire before taking the new item: a result never belongs to the item
            // accepted at the same edge
            if (o_out_valid && !i_out_stall) begin
                if (plain_q.size() == 0) begin
                    mism_cnt++;
                    if (mism_cnt <= 10) begin
                        $display("%0t: unexpected result first=%h second=%h", $realtime,
                                 o_plain_first, o_plain_second);
                    end
                end else begin
                    want = plain_q.pop_front();
                    if (want.first !== o_plain_first || want.second !== o_plain_second) begin
                        mism_cnt++;
                        if (mism_cnt <= 10) begin
                            $display("%0t: mismatch first exp=%h got=%h, second exp=%h got=%h",
                                     $realtime, want.first, o_plain_first,
                                     want.second, o_plain_second);
                        end
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                plain_q.push_back(tea_plain_of(i_cipher_first, i_cipher_second,
                                               seed_r, passes_code_r));
            end
        end
        o_pending    <= plain_q.size();
        o_fail_count <= mism_cnt;
    end

endmodule

FILE: tb/sv/tea_decrypt_seeded_key_unit_tb.sv
// Top of the seeded-key TEA decryptor testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tea_decrypt_seeded_key_unit_tb;
    import tdsk_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 8_000_000;
    localparam int          RAND_PHASES   = 12;
    localparam int          PHASE_ITEMS   = 153;
    localparam int          HOLD_CYCLES   = 1500;
    localparam int          TAIL_CYCLES   = 600;   // beyond the longest block latency

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_cipher_first;
    logic [31:0] i_cipher_second;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_plain_first;
    logic [31:0] o_plain_second;
    int          o_fail_count;
    int          o_pending;

    bit          hold_off_req;
    bit          hold_done;
    bit          tx_calm;
    int unsigned cycle_cnt;

    tea_decrypt_seeded_key_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cipher_first (i_cipher_first),
        .i_cipher_second(i_cipher_second),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_plain_first  (o_plain_first),
        .o_plain_second (o_plain_second)
    );

    tea_decrypt_seeded_key_checker chk (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mostly short idle stretches, the odd long one
    function automatic int idle_len();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(12, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic reg_write(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_block(input logic [31:0] w0, input logic [31:0] w1);
        int gap;
        gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cipher_first  <= w0;
        i_cipher_second <= w1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // block is idle once every expected item has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (o_pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // receiver: random stalls, calm stretches, and one long hold-off on request
    initial begin : receiver
        int stall_left;
        bit calm;
        stall_left  = 0;
        calm        = 1'b0;
        hold_done   = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 299) == 0) begin
                calm = !calm;
            end
            if (hold_off_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                stall_left = idle_len() - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] seed;
        logic [2:0]  code;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_in_valid      = 1'b0;
        i_cipher_first  = '0;
        i_cipher_second = '0;
        hold_off_req    = 1'b0;
        tx_calm         = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: seed 10000, single pass
        send_block(32'h0000_0000, 32'h0000_0000);
        send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(32'hFFFF_FFFF, 32'h0000_0000);
        send_block(32'h0000_0000, 32'hFFFF_FFFF);
        send_block(32'hAAAA_AAAA, 32'h5555_5555);
        send_block(32'h8000_0000, 32'h0000_0001);
        drain();

        // zero seed gives an all-zero key; eight passes; junk in the upper bits
        reg_write(REG_KEY_SEED, 32'hFFFF_0000);
        reg_write(REG_REPEAT_CODE, 32'h0000_0007);
        send_block(32'h0000_0000, 32'h0000_0000);
        send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(32'h1234_5678, 32'h9ABC_DEF0);
        drain();

        // all-ones seed; repeat code written with only excess bits set
        reg_write(REG_KEY_SEED, 32'hA5A5_FFFF);
        reg_write(REG_REPEAT_CODE, 32'hFFFF_FFF8);
        send_block(32'h0000_0000, 32'hFFFF_FFFF);
        send_block(32'h5555_5555, 32'hAAAA_AAAA);
        send_block(32'h0000_0001, 32'h8000_0000);
        drain();

        reg_write(REG_KEY_SEED, 32'h0000_0001);
        reg_write(REG_REPEAT_CODE, 32'h0000_0003);
        send_block(32'hDEAD_BEEF, 32'h0BAD_F00D);
        send_block(32'h7FFF_FFFF, 32'h8000_0000);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            seed = 16'($urandom_range(0, 16'hFFFF));
            code = 3'($urandom_range(0, 7));
            reg_write(REG_KEY_SEED, {16'($urandom_range(0, 16'hFFFF)), seed});
            reg_write(REG_REPEAT_CODE, {29'($urandom_range(0, 32'h1FFF_FFFF)), code});
            tx_calm = ($urandom_range(0, 3) == 0);
            if (ph == 2) begin
                hold_off_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_block(rand_word(), rand_word());
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (o_fail_count == 0 && o_pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
